[rtl/bvfg_pkg.sv]
package bvfg_pkg;

  localparam int CurvePoints = 19;

  // Discharge curve, state of charge at 4.20 V down to 3.30 V in 50 mV steps.
  localparam logic [6:0] CURVE_PCT [CurvePoints] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60, 7'd55,
    7'd50, 7'd45, 7'd40, 7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
  };

  localparam logic [10:0] CV_TOP = 11'd420;
  localparam logic [10:0] CV_BOT = 11'd330;
  localparam logic [10:0] CV_MAX = 11'd2047;

  localparam logic [8:0]  ALPHA_ONE  = 9'd256;
  localparam logic [11:0] HELD_SCALE = 12'd2560;     // cV to mV, in Q8
  localparam logic [31:0] ROUND_BIAS = 32'd327680;   // half of 655360
  localparam logic [15:0] RECIP_10   = 16'd52429;    // 2^19 / 10, rounded up
  localparam logic [7:0]  RECIP_5    = 8'd205;       // 2^10 / 5, rounded up

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MULT   = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;
  localparam logic [1:0] REG_LOWTHR = 2'd3;

  localparam logic [10:0] MULT_RST   = 11'd512;
  localparam logic [8:0]  ALPHA_RST  = 9'd51;
  localparam logic [15:0] WINDOW_RST = 16'd5000;
  localparam logic [10:0] LOWTHR_RST = 11'd340;

  typedef logic [3:0] state_t;

  // Linear interpolation on the discharge curve; the remainder is floored.
  function automatic logic [6:0] pct_of(input logic [10:0] v);
    logic [6:0]  d;
    logic [14:0] dm;
    logic [4:0]  seg;
    logic [6:0]  up;
    logic [2:0]  off;
    logic [6:0]  ph;
    logic [6:0]  pl;
    logic [3:0]  span;
    logic [5:0]  n;
    logic [13:0] nm;
    d    = '0;
    dm   = '0;
    seg  = '0;
    up   = '0;
    off  = '0;
    ph   = '0;
    pl   = '0;
    span = '0;
    n    = '0;
    nm   = '0;
    if (v >= CV_TOP) begin
      pct_of = 7'd100;
    end else if (v <= CV_BOT) begin
      pct_of = 7'd0;
    end else begin
      d    = 7'(CV_TOP - v);
      dm   = 15'(d * RECIP_5);
      seg  = dm[14:10];
      up   = 7'((7'(seg) + 7'd1) * 7'd5);
      off  = 3'(up - d);
      ph   = CURVE_PCT[seg];
      pl   = CURVE_PCT[5'(seg + 5'd1)];
      span = 4'(ph - pl);
      n    = 6'(off * span);
      nm   = 14'(n * RECIP_5);
      pct_of = 7'(pl + 7'(nm[13:10]));
    end
  endfunction

endpackage

[rtl/battery_voltage_fuel_gauge_unit.sv]
// Battery fuel gauge with a voltage cache, EMA smoothing and a Li-ion
// discharge-curve lookup.
// Input stream: in_tdata carries a timestamp in ms and an ADC reading in mV
// (0 marks a failed read). One result leaves on the output stream per input:
// voltage in cV, state of charge, low-battery flag, and in out_tuser a flag
// telling that the held voltage was reused.
// The update math runs on one shared 23x17 multiplier under a small
// sequencer: scale, weight the reading, scale the held value, weight it,
// add with rounding, and divide by ten through a reciprocal multiply.
// A reused or failed reading goes from the check straight to the output load;
// a fresh reading takes the check, five multiplier passes, the
// rounding add and the output load. in_tready is high only while the
// sequencer is idle, so no new item is taken before the last one is loaded out.
// The result sits in an output register; a stalled receiver holds it and the
// next item is still accepted, but it waits at the last step until the
// register frees. Synchronous reset clears the held voltage, the update
// time and the output valid, and loads the default register values.
// The user must write registers over APB only while no item is in flight; unchecked.
module battery_voltage_fuel_gauge_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // now_ms[31:0], adc_mv[43:32], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // voltage_cv[10:0], percent[17:11], low_battery[18]
  output logic [0:0]  out_tuser,  // from_cache[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam bvfg_pkg::state_t S_IDLE = 4'd0;
  localparam bvfg_pkg::state_t S_CHK  = 4'd1;
  localparam bvfg_pkg::state_t S_MX   = 4'd2;
  localparam bvfg_pkg::state_t S_MA   = 4'd3;
  localparam bvfg_pkg::state_t S_MH   = 4'd4;
  localparam bvfg_pkg::state_t S_MB   = 4'd5;
  localparam bvfg_pkg::state_t S_ADD  = 4'd6;
  localparam bvfg_pkg::state_t S_DIV  = 4'd7;
  localparam bvfg_pkg::state_t S_PCT  = 4'd8;

  bvfg_pkg::state_t state_r;

  logic [10:0] mult_r;
  logic [8:0]  alpha_r;
  logic [15:0] window_r;
  logic [10:0] lowthr_r;

  logic [31:0] now_r;
  logic [11:0] adc_r;
  logic [8:0]  a_r;
  logic [22:0] x_r;
  logic [31:0] p_r;
  logic [31:0] t_r;
  logic [15:0] q_r;
  logic [10:0] held_r;
  logic [31:0] last_r;
  logic        fc_r;

  logic        out_valid_r;
  logic [10:0] out_v_r;
  logic [6:0]  out_pct_r;
  logic        out_low_r;
  logic        out_fc_r;

  logic [22:0] mul_a;
  logic [16:0] mul_b;
  logic [39:0] prod;
  logic [31:0] sum;
  logic [31:0] elapsed;
  logic [20:0] cv_raw;
  logic        cfg_wr;
  logic        in_fire;
  logic        out_fire;
  logic        load_out;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_fire   = out_valid_r & out_tready;
  assign load_out   = (state_r == S_PCT) & (~out_valid_r | out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_low_r, out_pct_r, out_v_r};
  assign out_tuser  = out_fc_r;

  assign elapsed = now_r - last_r;
  assign sum     = p_r + t_r + bvfg_pkg::ROUND_BIAS;
  assign cv_raw  = prod[39:19];

  always_comb begin
    unique case (cfg_paddr[3:2])
      bvfg_pkg::REG_MULT:   cfg_prdata = {21'd0, mult_r};
      bvfg_pkg::REG_ALPHA:  cfg_prdata = {23'd0, alpha_r};
      bvfg_pkg::REG_WINDOW: cfg_prdata = {16'd0, window_r};
      bvfg_pkg::REG_LOWTHR: cfg_prdata = {21'd0, lowthr_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (state_r)
      S_MX: begin
        mul_a = {11'd0, adc_r};
        mul_b = {6'd0, mult_r};
      end
      S_MA: begin
        mul_a = x_r;
        mul_b = {8'd0, a_r};
      end
      S_MH: begin
        mul_a = {12'd0, held_r};
        mul_b = {5'd0, bvfg_pkg::HELD_SCALE};
      end
      S_MB: begin
        mul_a = t_r[22:0];
        mul_b = {8'd0, 9'(bvfg_pkg::ALPHA_ONE - a_r)};
      end
      S_DIV: begin
        mul_a = {7'd0, q_r};
        mul_b = {1'b0, bvfg_pkg::RECIP_10};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 40'(mul_a) * 40'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r   <= bvfg_pkg::MULT_RST;
      alpha_r  <= bvfg_pkg::ALPHA_RST;
      window_r <= bvfg_pkg::WINDOW_RST;
      lowthr_r <= bvfg_pkg::LOWTHR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        bvfg_pkg::REG_MULT:   mult_r   <= cfg_pwdata[10:0];
        bvfg_pkg::REG_ALPHA:  alpha_r  <= cfg_pwdata[8:0];
        bvfg_pkg::REG_WINDOW: window_r <= cfg_pwdata[15:0];
        bvfg_pkg::REG_LOWTHR: lowthr_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            now_r   <= in_tdata[31:0];
            adc_r   <= in_tdata[43:32];
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (held_r != '0 && elapsed < {16'd0, window_r}) begin
            fc_r    <= 1'b1;
            state_r <= S_PCT;
          end else if (adc_r == '0) begin
            fc_r    <= (held_r != '0);
            state_r <= S_PCT;
          end else begin
            fc_r <= 1'b0;
            // With nothing held the new reading is taken as it is.
            if (held_r == '0 || alpha_r > bvfg_pkg::ALPHA_ONE) begin
              a_r <= bvfg_pkg::ALPHA_ONE;
            end else begin
              a_r <= alpha_r;
            end
            state_r <= S_MX;
          end
        end
        S_MX: begin
          x_r     <= prod[22:0];
          state_r <= S_MA;
        end
        S_MA: begin
          p_r     <= prod[31:0];
          state_r <= S_MH;
        end
        S_MH: begin
          t_r     <= prod[31:0];
          state_r <= S_MB;
        end
        S_MB: begin
          t_r     <= prod[31:0];
          state_r <= S_ADD;
        end
        S_ADD: begin
          q_r     <= sum[31:16];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cv_raw > 21'(bvfg_pkg::CV_MAX)) begin
            held_r <= bvfg_pkg::CV_MAX;
          end else begin
            held_r <= cv_raw[10:0];
          end
          last_r  <= now_r;
          state_r <= S_PCT;
        end
        S_PCT: begin
          if (load_out) begin
            out_v_r   <= held_r;
            out_pct_r <= bvfg_pkg::pct_of(held_r);
            out_low_r <= (held_r != '0) && (held_r < lowthr_r);
            out_fc_r  <= fc_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
